// File: rtl/tsa_pkg.sv
package tsa_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned SlotCountDef = 31;
  localparam int unsigned TagBitsDef   = 16;

  // Fixed field widths
  localparam int unsigned MaskBits   = 31;
  localparam int unsigned SlotIdxW   = 5;
  localparam int unsigned OrderW     = 7;
  localparam int unsigned TagInW     = 16;
  localparam int unsigned CfgDataW   = 31;
  localparam int unsigned CfgIdxW    = 1;

  // Register reset values
  localparam logic [MaskBits-1:0] MaskReset  = 31'd2080176125;
  localparam logic [OrderW-1:0]   FloorReset = 7'd7;

  typedef enum logic [0:0] {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } tsa_cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_RESERVED_MASK = 1'b0,
    REG_ORDER_FLOOR   = 1'b1
  } tsa_reg_e;

  // Work request from the input stage to the slot table
  typedef struct packed {
    logic     fire;
    tsa_cmd_e cmd;
  } tsa_ctl_t;

endpackage

// File: rtl/tsa_slot_table.sv
module tsa_slot_table #(
  parameter int unsigned SLOT_COUNT = 31,
  parameter int unsigned TAG_BITS   = 16,
  parameter int unsigned IDX_W      = $clog2(SLOT_COUNT)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tsa_pkg::tsa_ctl_t              ctl_i,
  input  logic [TAG_BITS-1:0]            tag_i,
  input  logic                           mask_we_i,
  input  logic [tsa_pkg::MaskBits-1:0]   mask_i,
  output logic                           found_o,
  output logic [IDX_W-1:0]               hit_idx_o
);
  import tsa_pkg::*;

  logic [MaskBits-1:0]   mask_q;
  logic [SLOT_COUNT-1:0] busy_q, busy_d;
  logic [TAG_BITS-1:0]   owner_q [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] rsv;
  logic [SLOT_COUNT-1:0] match;
  logic [SLOT_COUNT-1:0] cand;
  logic [SLOT_COUNT-1:0] pick;
  logic                  do_alloc;
  logic                  do_free;

  // Reserved mask register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= MaskReset;
    end else if (mask_we_i) begin
      mask_q <= mask_i;
    end
  end

  // Per-slot reserve bit and tag compare; slots past the mask are never reserved
  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_slot
    if (i < MaskBits) begin : g_rsv
      assign rsv[i] = mask_q[i];
    end else begin : g_open
      assign rsv[i] = 1'b0;
    end
    assign match[i] = (owner_q[i] == tag_i);

    // Owner tag, written on a grant only
    always_ff @(posedge clk_i) begin
      if (do_alloc && pick[i]) begin
        owner_q[i] <= tag_i;
      end
    end
  end

  // Candidate slots, then isolate the lowest one
  assign cand = (ctl_i.cmd == CMD_ALLOC) ? (~busy_q & ~rsv) : (busy_q & ~rsv & match);
  assign pick = cand & (~cand + SLOT_COUNT'(1));
  assign found_o = |cand;

  always_comb begin
    hit_idx_o = '0;
    for (int unsigned i = 0; i < SLOT_COUNT; i++) begin
      if (pick[i]) begin
        hit_idx_o = hit_idx_o | IDX_W'(i);
      end
    end
  end

  assign do_alloc = ctl_i.fire && (ctl_i.cmd == CMD_ALLOC) && found_o;
  assign do_free  = ctl_i.fire && (ctl_i.cmd == CMD_FREE) && found_o;

  // Busy bits
  always_comb begin
    busy_d = busy_q;
    if (do_alloc) begin
      busy_d = busy_q | pick;
    end else if (do_free) begin
      busy_d = busy_q & ~pick;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0;
    end else begin
      busy_q <= busy_d;
    end
  end

endmodule

// File: rtl/tsa_order_counter.sv
module tsa_order_counter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         floor_we_i,
  input  logic [tsa_pkg::OrderW-1:0]   floor_i,
  input  logic                         grant_i,
  output logic [tsa_pkg::OrderW-1:0]   order_o
);
  import tsa_pkg::*;

  logic [OrderW-1:0] floor_q;
  logic [OrderW-1:0] cnt_q, cnt_d;
  logic [OrderW-1:0] cnt_inc;

  // Advance with natural 7-bit wrap, then clamp up to the floor
  assign cnt_inc = cnt_q + OrderW'(1);

  always_comb begin
    cnt_d = cnt_q;
    if (floor_we_i) begin
      cnt_d = floor_i;
    end else if (grant_i) begin
      cnt_d = (cnt_inc < floor_q) ? floor_q : cnt_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q <= FloorReset;
      cnt_q   <= FloorReset;
    end else begin
      cnt_q <= cnt_d;
      if (floor_we_i) begin
        floor_q <= floor_i;
      end
    end
  end

  assign order_o = cnt_q;

endmodule

// File: rtl/tagged_slot_allocator.sv
// Slot allocator with owner tags. An allocate beat grants the lowest slot that
// is neither busy nor reserved and returns it with an order number; a free beat
// releases the lowest unreserved busy slot holding the tag. Each beat gives one
// result beat, with ok low and zero fields when nothing fits. The block takes one
// beat per cycle unless the result side stalls: a beat sits in the input
// register, the free-slot priority encode and parallel tag compare resolve
// from it combinationally, and the result register captures the outcome as
// the beat moves on. The input stalls only when both registers are full and
// the result side stalls. Back-to-back beats see the table updates of the
// beat before. Configuration writes (index 0 reserved mask, index 1 order
// floor, which also reloads the order counter) must happen while no beat is
// in flight.
module tagged_slot_allocator #(
  parameter int unsigned SLOT_COUNT = tsa_pkg::SlotCountDef,
  parameter int unsigned TAG_BITS   = tsa_pkg::TagBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          cmd_i,
  input  logic [tsa_pkg::TagInW-1:0]    owner_tag_i,
  // Result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          ok_o,
  output logic [tsa_pkg::SlotIdxW-1:0]  slot_index_o,
  output logic [tsa_pkg::OrderW-1:0]    order_number_o,
  // Configuration
  input  logic                          cfg_we_i,
  input  logic [tsa_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tsa_pkg::CfgDataW-1:0]  cfg_data_i
);
  import tsa_pkg::*;

  localparam int unsigned IdxW = $clog2(SLOT_COUNT);

  logic               s1_valid_q;
  tsa_cmd_e           s1_cmd_q;
  logic [TagInW-1:0]  s1_tag_q;
  logic               advance;
  logic               in_accept;
  tsa_ctl_t           ctl;
  logic [TAG_BITS-1:0] tag_w;
  logic               found;
  logic [IdxW-1:0]    hit_idx;
  logic [OrderW-1:0]  order_cur;
  logic               grant;
  logic               mask_we;
  logic               floor_we;

  logic               out_valid_q;
  logic               ok_q;
  logic [SlotIdxW-1:0] slot_q;
  logic [OrderW-1:0]  order_q;

  // Handshake: input stage moves on when the result register is free or drains
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_cmd_q <= tsa_cmd_e'(cmd_i);
      s1_tag_q <= owner_tag_i;
    end
  end

  // Config decode
  assign mask_we  = cfg_we_i && (tsa_reg_e'(cfg_idx_i) == REG_RESERVED_MASK);
  assign floor_we = cfg_we_i && (tsa_reg_e'(cfg_idx_i) == REG_ORDER_FLOOR);

  assign ctl.fire = s1_valid_q && advance;
  assign ctl.cmd  = s1_cmd_q;
  assign tag_w    = TAG_BITS'(s1_tag_q);
  assign grant    = ctl.fire && (s1_cmd_q == CMD_ALLOC) && found;

  tsa_slot_table #(
    .SLOT_COUNT (SLOT_COUNT),
    .TAG_BITS   (TAG_BITS),
    .IDX_W      (IdxW)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .tag_i     (tag_w),
    .mask_we_i (mask_we),
    .mask_i    (cfg_data_i[MaskBits-1:0]),
    .found_o   (found),
    .hit_idx_o (hit_idx)
  );

  tsa_order_counter u_order (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .floor_we_i (floor_we),
    .floor_i    (cfg_data_i[OrderW-1:0]),
    .grant_i    (grant),
    .order_o    (order_cur)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.fire) begin
      ok_q    <= found;
      slot_q  <= found ? SlotIdxW'(hit_idx) : '0;
      order_q <= grant ? order_cur : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign ok_o           = ok_q;
  assign slot_index_o   = slot_q;
  assign order_number_o = order_q;

  // Checks
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> (slot_index_o == '0) && (order_number_o == '0))
    else $error("failed beat carries nonzero fields");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

  a_grant_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.fire |=> out_valid_o)
    else $error("processed beat did not reach the result register");

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import tsa_pkg::*;

  localparam int SLOTS        = SlotCountDef;
  localparam int RESET_CYCLES = 11;
  localparam int DRAIN_CYCLES = 8;
  localparam int RUN_LIMIT_NS = 2_000_000;

  // One expected result beat
  typedef struct packed {
    logic                ok;
    logic [SlotIdxW-1:0] slot;
    logic [OrderW-1:0]   order;
  } grant_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  tsa_cmd_e            cmd_i       = CMD_ALLOC;
  logic [TagInW-1:0]   owner_tag_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                ok_o;
  logic [SlotIdxW-1:0] slot_index_o;
  logic [OrderW-1:0]   order_number_o;
  logic                cfg_we_i    = 1'b0;
  tsa_reg_e            cfg_idx_i   = REG_RESERVED_MASK;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  // Shadow of the slot table and registers
  logic [SLOTS-1:0]    slot_held;
  logic [TagInW-1:0]   slot_tag [SLOTS];
  logic [MaskBits-1:0] held_back_mask;
  logic [OrderW-1:0]   floor_reg;
  logic [OrderW-1:0]   order_ctr;
  grant_t              pending_grants[$];

  int mismatches     = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_target    = 0;
  int hold_done      = 0;

  tagged_slot_allocator i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .owner_tag_i    (owner_tag_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .ok_o           (ok_o),
    .slot_index_o   (slot_index_o),
    .order_number_o (order_number_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Grant or release on the shadow table; returns the beat the block should give
  function automatic grant_t table_step(tsa_cmd_e op, logic [TagInW-1:0] tag);
    grant_t           res;
    logic [OrderW-1:0] nxt;
    res = '0;
    if (op == CMD_ALLOC) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (!res.ok && !slot_held[i] && !held_back_mask[i]) begin
          res.ok       = 1'b1;
          res.slot     = SlotIdxW'(i);
          slot_held[i] = 1'b1;
          slot_tag[i]  = tag;
        end
      end
      if (res.ok) begin
        res.order = order_ctr;
        nxt       = order_ctr + 1'b1;
        order_ctr = (nxt < floor_reg) ? floor_reg : nxt;
      end
    end else begin
      for (int i = 0; i < SLOTS; i++) begin
        if (!res.ok && slot_held[i] && !held_back_mask[i] && slot_tag[i] == tag) begin
          res.ok       = 1'b1;
          res.slot     = SlotIdxW'(i);
          slot_held[i] = 1'b0;
        end
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // Monitor: register writes, accepted beats and result beats, all at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    grant_t want;
    if (!rst_ni) begin
      slot_held      = '0;
      held_back_mask = MaskReset;
      floor_reg      = FloorReset;
      order_ctr      = FloorReset;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_RESERVED_MASK: held_back_mask = cfg_data_i[MaskBits-1:0];
          REG_ORDER_FLOOR: begin
            floor_reg = cfg_data_i[OrderW-1:0];
            order_ctr = cfg_data_i[OrderW-1:0];
          end
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        pending_grants.push_back(table_step(cmd_i, owner_tag_i));
      end
      if (out_valid_o === 1'b1 && !out_stall_i) begin
        if (pending_grants.size() == 0) begin
          report_mismatch("result beat with no request pending");
        end else begin
          want = pending_grants.pop_front();
          if (ok_o !== want.ok)
            report_mismatch($sformatf("ok %b, want %b", ok_o, want.ok));
          if (slot_index_o !== want.slot)
            report_mismatch($sformatf("slot_index %0d, want %0d", slot_index_o, want.slot));
          if (order_number_o !== want.order)
            report_mismatch($sformatf("order_number %0d, want %0d",
                                      order_number_o, want.order));
        end
      end
    end
  end

  // Result side: random stall, or a counted hold-off when one is requested
  always @(negedge clk_i) begin
    if (hold_done < hold_target) begin
      out_stall_i <= 1'b1;
      hold_done   <= hold_done + 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Offer one beat; returns right after the edge that takes it
  task automatic send_beat(tsa_cmd_e op, logic [TagInW-1:0] tag);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_i       <= op;
    owner_tag_i <= tag;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_results_drained();
    while (pending_grants.size() != 0) @(posedge clk_i);
  endtask

  // Drop valid, let every result come back, then wait with the inputs quiet
  task automatic settle_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait_results_drained();
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(tsa_reg_e idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Floor write with random junk above the register bits
  task automatic write_floor(logic [OrderW-1:0] value);
    write_reg(REG_ORDER_FLOOR, (CfgDataW'($urandom) & ~CfgDataW'(7'h7f)) | value);
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Mostly allocs and frees of held tags; some misses and repeated tags
  task automatic send_random_beat(int alloc_pct, logic [TagInW-1:0] tag_base);
    logic [TagInW-1:0] tag;
    int                busy_idx[$];
    tag = TagInW'($urandom);
    if ($urandom_range(99) < alloc_pct) begin
      if ($urandom_range(1)) tag = tag_base ^ TagInW'($urandom_range(7));
      send_beat(CMD_ALLOC, tag);
    end else begin
      for (int i = 0; i < SLOTS; i++) if (slot_held[i]) busy_idx.push_back(i);
      if (busy_idx.size() != 0 && $urandom_range(99) < 80)
        tag = slot_tag[busy_idx[$urandom_range(busy_idx.size() - 1)]];
      send_beat(CMD_FREE, tag);
    end
  endtask

  task automatic run_phase(logic [MaskBits-1:0] mask, logic [OrderW-1:0] floor_val,
                           int alloc_pct, int beats);
    logic [TagInW-1:0] tag_base;
    settle_idle();
    write_reg(REG_RESERVED_MASK, mask);
    write_floor(floor_val);
    tag_base = TagInW'($urandom);
    repeat (beats) send_random_beat(alloc_pct, tag_base);
  endtask

  // Reset registers: extreme tags, a repeated tag, a miss, lowest-first release
  task automatic test_basic_grants();
    send_beat(CMD_ALLOC, 16'h0000);
    send_beat(CMD_ALLOC, 16'hffff);
    send_beat(CMD_ALLOC, 16'hffff);
    send_beat(CMD_FREE,  16'hffff);
    send_beat(CMD_FREE,  16'h1234);
    send_beat(CMD_FREE,  16'hffff);
    send_beat(CMD_FREE,  16'h0000);
  endtask

  // Fill every open slot, then one alloc too many
  task automatic test_table_full();
    for (int k = 0; k < 6; k++) send_beat(CMD_ALLOC, 16'h0a00 + 16'(k));
  endtask

  // Held slots under the mask are neither freed nor granted until unmasked
  task automatic test_reserved_slots();
    settle_idle();
    write_reg(REG_RESERVED_MASK, {MaskBits{1'b1}});
    send_beat(CMD_FREE,  16'h0a00);
    send_beat(CMD_ALLOC, 16'h0bbb);
    settle_idle();
    write_reg(REG_RESERVED_MASK, '0);
    for (int k = 0; k < 5; k++) send_beat(CMD_FREE, 16'h0a00 + 16'(k));
  endtask

  // Counter wrap past 127 back up to the floor, and the top floor value
  task automatic test_order_wrap();
    settle_idle();
    write_floor(7'd125);
    repeat (4) send_beat(CMD_ALLOC, TagInW'($urandom));
    settle_idle();
    write_floor(7'd127);
    send_beat(CMD_ALLOC, TagInW'($urandom));
  endtask

  task automatic test_random_traffic();
    run_phase('0, 7'd0, 60, 220);
    run_phase(MaskBits'($urandom), 7'($urandom_range(1, 126)), 55, 160);
    set_idling(54, 29);
    run_phase({MaskBits{1'b1}}, 7'd127, 50, 40);
    run_phase({1'b0, {(MaskBits-1){1'b1}}}, 7'd126, 50, 60);
    run_phase(MaskBits'($urandom), 7'($urandom), 70, 200);
    set_idling(0, 0);
    run_phase('0, 7'd0, 50, 300);
    run_phase(MaskBits'($urandom) & MaskBits'($urandom), 7'd100, 40, 250);
  endtask

  // Result side holds off while beats keep coming, so the input stalls
  task automatic test_backpressure();
    logic [TagInW-1:0] tag_base;
    settle_idle();
    write_reg(REG_RESERVED_MASK, '0);
    tag_base = TagInW'($urandom);
    @(posedge clk_i);
    hold_target = hold_target + 80;
    repeat (40) send_random_beat(60, tag_base);
    settle_idle();
  endtask

  initial begin
    set_idling(29, 54);
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_basic_grants();
    test_table_full();
    test_reserved_slots();
    test_order_wrap();
    test_random_traffic();
    test_backpressure();
    settle_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("FAIL");
    $finish;
  end

endmodule

// File: sim.f
rtl/tsa_pkg.sv
rtl/tsa_slot_table.sv
rtl/tsa_order_counter.sv
rtl/tagged_slot_allocator.sv
test/testbench.sv
